// File: sv/sobel_energy_map_unit_assert.svh
// Assertion macros for the sobel energy map block.
// Used by the port checker; depends on clk and arst_n in the including scope.
`ifndef SOBEL_ENERGY_MAP_UNIT_ASSERT_SVH
`define SOBEL_ENERGY_MAP_UNIT_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("sem check failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("sem check failed");

`endif

// File: sv/sem_pkg.sv
// Shared types and constants for the sobel energy map block.
// No dependencies.
package sem_pkg;

	localparam int PIXEL_BITS  = 8;
	localparam int PIXEL_CH    = 4;
	localparam int PIX_W       = PIXEL_BITS * PIXEL_CH;
	localparam int ENERGY_W    = 11;
	localparam int FW_W        = 11;
	localparam int FH_W        = 13;
	localparam int CC_W        = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int ROOT_STEPS  = 11;
	localparam int SQ_W        = 2 * ROOT_STEPS;
	localparam int SUM_W       = ENERGY_W + 2;
	localparam int DIV3_MUL    = 43691;
	localparam int DIV3_SHIFT  = 17;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] chan0;
		logic [PIXEL_BITS-1:0] chan1;
		logic [PIXEL_BITS-1:0] chan2;
		logic [PIXEL_BITS-1:0] chan3;
		logic                  flush;
	} in_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic                frame_end;
	} out_t;

	// 3x3 neighborhood of one channel, center not needed
	typedef struct packed {
		logic [PIXEL_BITS-1:0] tl;
		logic [PIXEL_BITS-1:0] tc;
		logic [PIXEL_BITS-1:0] tr;
		logic [PIXEL_BITS-1:0] ml;
		logic [PIXEL_BITS-1:0] mr;
		logic [PIXEL_BITS-1:0] bl;
		logic [PIXEL_BITS-1:0] bc;
		logic [PIXEL_BITS-1:0] br;
	} nbhd_t;

	typedef enum logic [1:0] {LP_IDLE, LP_SQ, LP_RT} lane_ph_t;

	typedef enum logic [2:0] {ST_IDLE, ST_WIN, ST_SEL, ST_LANE, ST_MERGE, ST_HOLD} sem_state_t;

endpackage

// File: sv/sem_lane.sv
// One channel lane: Sobel gradients, squared magnitude, digit-serial floor sqrt.
// Depends on sem_pkg.
module sem_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sem_pkg::nbhd_t                nb,
	output logic                          done,
	output logic [sem_pkg::ENERGY_W-1:0]  mag
);

	sem_pkg::lane_ph_t ph_q, ph_n;
	logic [3:0]  step_q;
	logic        done_q;

	logic [9:0]  xp, xn, yp, yn;
	logic signed [10:0] gx, gy;
	logic signed [10:0] gx_s1, gy_s1;
	logic signed [21:0] gx2, gy2;
	logic [sem_pkg::SQ_W-1:0] v_q;
	logic [11:0] rem_q;
	logic [sem_pkg::ENERGY_W-1:0] root_q;
	logic [13:0] rem_sh, trial;
	logic [13:0] rem_n;
	logic        take;

	assign xp = {2'b0, nb.tr} + {1'b0, nb.mr, 1'b0} + {2'b0, nb.br};
	assign xn = {2'b0, nb.tl} + {1'b0, nb.ml, 1'b0} + {2'b0, nb.bl};
	assign yp = {2'b0, nb.tl} + {1'b0, nb.tc, 1'b0} + {2'b0, nb.tr};
	assign yn = {2'b0, nb.bl} + {1'b0, nb.bc, 1'b0} + {2'b0, nb.br};
	assign gx = $signed({1'b0, xp}) - $signed({1'b0, xn});
	assign gy = $signed({1'b0, yp}) - $signed({1'b0, yn});
	assign gx2 = gx_s1 * gx_s1;
	assign gy2 = gy_s1 * gy_s1;

	// one root bit per cycle: bring down two radicand bits, try (root<<2)|1
	assign rem_sh = {rem_q, v_q[sem_pkg::SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;
	assign rem_n  = take ? rem_sh - trial : rem_sh;

	always_comb begin
		ph_n = ph_q;
		case (ph_q)
			sem_pkg::LP_IDLE: if (start) ph_n = sem_pkg::LP_SQ;
			sem_pkg::LP_SQ:   ph_n = sem_pkg::LP_RT;
			sem_pkg::LP_RT:   if (step_q == 4'(sem_pkg::ROOT_STEPS - 1)) ph_n = sem_pkg::LP_IDLE;
			default:          ph_n = sem_pkg::LP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= sem_pkg::LP_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_n;
			done_q <= (ph_q == sem_pkg::LP_RT) && (ph_n == sem_pkg::LP_IDLE);
			if (ph_q == sem_pkg::LP_RT) step_q <= step_q + 4'd1;
			else step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == sem_pkg::LP_IDLE && start) begin
			gx_s1 <= gx;
			gy_s1 <= gy;
		end
		if (ph_q == sem_pkg::LP_SQ) begin
			v_q    <= $unsigned(gx2) + $unsigned(gy2);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (ph_q == sem_pkg::LP_RT) begin
			v_q    <= {v_q[sem_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= rem_n[11:0];
			root_q <= {root_q[sem_pkg::ENERGY_W-2:0], take};
		end
	end

	assign done = done_q;
	assign mag  = root_q;

endmodule

// File: sv/sem_merge.sv
// Merging stage: sums the lane magnitudes in use and divides by the channel count.
// Depends on sem_pkg.
module sem_merge #(
	parameter int LANES = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [LANES-1:0][sem_pkg::ENERGY_W-1:0] mag,
	input  logic [sem_pkg::CC_W-1:0]               nch,
	output logic                                   done,
	output logic [sem_pkg::ENERGY_W-1:0]           energy
);

	logic                         v_s1, v_s2;
	logic [sem_pkg::SUM_W-1:0]    sum, sum_s1;
	logic [28:0]                  prod;
	logic [sem_pkg::SUM_W-1:0]    quo;
	logic [sem_pkg::ENERGY_W-1:0] energy_s2;

	always_comb begin
		sum = '0;
		for (int i = 0; i < LANES; i++) begin
			if (i < int'(nch)) sum = sum + sem_pkg::SUM_W'(mag[i]);
		end
	end

	// divide by 3 through the reciprocal; exact for sums of this size
	assign prod = 29'(sum_s1) * 29'(sem_pkg::DIV3_MUL);

	always_comb begin
		case (nch)
			3'd1:    quo = sum_s1;
			3'd2:    quo = sum_s1 >> 1;
			3'd3:    quo = sem_pkg::SUM_W'(prod >> sem_pkg::DIV3_SHIFT);
			default: quo = sum_s1 >> 2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) sum_s1 <= sum;
		if (v_s1) energy_s2 <= quo[sem_pkg::ENERGY_W-1:0];
	end

	assign done   = v_s2;
	assign energy = energy_s2;

endmodule

// File: sv/sobel_energy_map_unit.sv
// Streaming Sobel energy map. Raster pixels of up to four 8-bit channels come in one beat
// each; each result beat carries the channel-averaged floor(sqrt(Gx^2+Gy^2)) with replicated
// borders and lags its pixel by frame_width+1 beats. After a frame, send frame_width+1
// beats with flush set to drain; the last result has frame_end set. A pixel beat that
// produces a result passes through the window update, lane start, squaring, the
// 11-step digit-serial square root in each channel lane and the two merge stages;
// beats that produce no result only update the window, and a flush beat during the
// frame is dropped. A finished result that finds the output register still holding an
// unaccepted beat keeps the core, and so the input, stalled until out_ready frees it.
// Any register write restarts the frame.
// Depends on sem_pkg, sem_lane, sem_merge.
module sobel_energy_map_unit #(
	parameter int MAX_WIDTH     = 1024,
	parameter int CHANNEL_LANES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sem_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sem_pkg::out_t                   out_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = sem_pkg::PIX_W;
	localparam int PB = sem_pkg::PIXEL_BITS;
	localparam int RW = sem_pkg::FH_W + 1;

	// configuration
	logic [sem_pkg::FW_W-1:0] fw_q;
	logic [sem_pkg::FH_W-1:0] fh_q;
	logic [sem_pkg::CC_W-1:0] cc_q;
	logic [AW:0]              eff_w;
	logic [sem_pkg::FH_W-1:0] eff_h;
	logic [sem_pkg::CC_W-1:0] eff_c;

	// position
	logic [AW-1:0]            col_q;
	logic [sem_pkg::FH_W-1:0] row_q;
	logic [AW:0]              lag_q;
	logic                     drain_q;

	sem_pkg::sem_state_t st_q, st_n;
	logic in_acc, go;
	logic lane_start, merge_start, out_load, out_free;

	logic [AW-1:0]            c_n;
	logic [RW-1:0]            r_n;
	logic [PW-1:0]            pix_n;
	logic                     emit_n;
	logic [AW:0]              x_n;
	logic [RW-1:0]            y_n;

	logic [AW-1:0] c_q;
	logic [PW-1:0] pix_q;
	logic          emit_q, oldsel_q, xl_q, xr_q, yt_q, yb_q, fend_q;

	// line stores
	logic [PW-1:0] upper_mem [MAX_WIDTH];
	logic [PW-1:0] lower_mem [MAX_WIDTH];
	logic [PW-1:0] up_s1, lo_s1;

	logic [PW-1:0] win_q [3][3];
	logic [PW-1:0] old_q [3][3];

	logic [1:0] cl, cc, cr, rt, rb;
	logic [PW-1:0] p_tl, p_tc, p_tr, p_ml, p_mr, p_bl, p_bc, p_br;

	logic [CHANNEL_LANES-1:0]                           lane_done;
	logic [CHANNEL_LANES-1:0][sem_pkg::ENERGY_W-1:0]    lane_mag;
	logic                                               merge_done;
	logic [sem_pkg::ENERGY_W-1:0]                       merge_energy;

	logic          out_valid_q;
	sem_pkg::out_t out_q;

	always_comb begin
		if (fw_q == '0) eff_w = (AW+1)'(1);
		else if (32'(fw_q) > MAX_WIDTH) eff_w = (AW+1)'(MAX_WIDTH);
		else eff_w = (AW+1)'(fw_q);
		eff_h = (fh_q == '0) ? sem_pkg::FH_W'(1) : fh_q;
		if (cc_q == '0) eff_c = sem_pkg::CC_W'(1);
		else if (32'(cc_q) > CHANNEL_LANES) eff_c = sem_pkg::CC_W'(CHANNEL_LANES);
		else eff_c = cc_q;
	end

	assign in_acc   = in_valid && in_ready;
	assign go       = in_acc && (drain_q || !in_data.flush);
	assign out_free = !out_valid_q || out_ready;

	// where this beat lands and which result it releases
	always_comb begin
		if (drain_q) begin
			pix_n = '0;
			if (lag_q < eff_w) begin
				c_n = lag_q[AW-1:0];
				r_n = {1'b0, eff_h};
			end else begin
				c_n = '0;
				r_n = {1'b0, eff_h} + RW'(1);
			end
		end else begin
			c_n   = col_q;
			r_n   = {1'b0, row_q};
			pix_n = {in_data.chan3, in_data.chan2, in_data.chan1, in_data.chan0};
		end
		emit_n = (r_n >= RW'(2)) || (r_n == RW'(1) && c_n != '0);
		if (c_n != '0) begin
			x_n = (AW+1)'(c_n) - (AW+1)'(1);
			y_n = r_n - RW'(1);
		end else begin
			x_n = eff_w - (AW+1)'(1);
			y_n = r_n - RW'(2);
		end
	end

	always_comb begin
		st_n        = st_q;
		in_ready    = 1'b0;
		lane_start  = 1'b0;
		merge_start = 1'b0;
		out_load    = 1'b0;
		case (st_q)
			sem_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (go) st_n = sem_pkg::ST_WIN;
			end
			sem_pkg::ST_WIN: st_n = emit_q ? sem_pkg::ST_SEL : sem_pkg::ST_IDLE;
			sem_pkg::ST_SEL: begin
				lane_start = 1'b1;
				st_n       = sem_pkg::ST_LANE;
			end
			sem_pkg::ST_LANE: begin
				if (&lane_done) begin
					merge_start = 1'b1;
					st_n        = sem_pkg::ST_MERGE;
				end
			end
			sem_pkg::ST_MERGE: begin
				if (merge_done) begin
					if (out_free) begin
						out_load = 1'b1;
						st_n     = sem_pkg::ST_IDLE;
					end else begin
						st_n = sem_pkg::ST_HOLD;
					end
				end
			end
			sem_pkg::ST_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					st_n     = sem_pkg::ST_IDLE;
				end
			end
			default: st_n = sem_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= sem_pkg::ST_IDLE;
			fw_q    <= sem_pkg::FW_W'(1024);
			fh_q    <= sem_pkg::FH_W'(1024);
			cc_q    <= sem_pkg::CC_W'(3);
			col_q   <= '0;
			row_q   <= '0;
			lag_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (cfg_we && cfg_index != sem_pkg::CFG_IDX_W'(3)) begin
				case (cfg_index)
					sem_pkg::REG_FRAME_WIDTH:   fw_q <= cfg_data[sem_pkg::FW_W-1:0];
					sem_pkg::REG_FRAME_HEIGHT:  fh_q <= cfg_data[sem_pkg::FH_W-1:0];
					sem_pkg::REG_CHANNEL_COUNT: cc_q <= cfg_data[sem_pkg::CC_W-1:0];
					default: ;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				lag_q   <= '0;
				drain_q <= 1'b0;
			end else if (go) begin
				if (drain_q) begin
					if (lag_q >= eff_w) begin
						drain_q <= 1'b0;
						lag_q   <= '0;
						col_q   <= '0;
						row_q   <= '0;
					end else begin
						lag_q <= lag_q + (AW+1)'(1);
					end
				end else if ((AW+1)'(col_q) + (AW+1)'(1) >= eff_w) begin
					col_q <= '0;
					if ({1'b0, row_q} + RW'(1) >= {1'b0, eff_h}) begin
						row_q   <= '0;
						drain_q <= 1'b1;
						lag_q   <= '0;
					end else begin
						row_q <= row_q + sem_pkg::FH_W'(1);
					end
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// per-beat payload captured at accept
	always_ff @(posedge clk) begin
		if (go) begin
			c_q      <= c_n;
			pix_q    <= pix_n;
			emit_q   <= emit_n;
			oldsel_q <= (c_n == '0);
			xl_q     <= (x_n == '0);
			xr_q     <= (x_n + (AW+1)'(1) >= eff_w);
			yt_q     <= (y_n == '0);
			yb_q     <= (y_n + RW'(1) >= {1'b0, eff_h});
			fend_q   <= (x_n + (AW+1)'(1) == eff_w) && (y_n + RW'(1) == {1'b0, eff_h});
			up_s1    <= upper_mem[c_n];
			lo_s1    <= lower_mem[c_n];
		end
		if (st_q == sem_pkg::ST_WIN) begin
			upper_mem[c_q] <= lo_s1;
			lower_mem[c_q] <= pix_q;
			old_q          <= win_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			end
		end else if (st_q == sem_pkg::ST_WIN) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_s1;
			win_q[1][2] <= lo_s1;
			win_q[2][2] <= pix_q;
		end
	end

	// column zero releases the last pixel of the previous row from the pre-shift window
	always_comb begin
		cc = oldsel_q ? 2'd2 : 2'd1;
		cl = xl_q ? cc : (oldsel_q ? 2'd1 : 2'd0);
		cr = xr_q ? cc : 2'd2;
		rt = yt_q ? 2'd1 : 2'd0;
		rb = yb_q ? 2'd1 : 2'd2;
		if (oldsel_q) begin
			p_tl = old_q[rt][cl];
			p_tc = old_q[rt][cc];
			p_tr = old_q[rt][cr];
			p_ml = old_q[1][cl];
			p_mr = old_q[1][cr];
			p_bl = old_q[rb][cl];
			p_bc = old_q[rb][cc];
			p_br = old_q[rb][cr];
		end else begin
			p_tl = win_q[rt][cl];
			p_tc = win_q[rt][cc];
			p_tr = win_q[rt][cr];
			p_ml = win_q[1][cl];
			p_mr = win_q[1][cr];
			p_bl = win_q[rb][cl];
			p_bc = win_q[rb][cc];
			p_br = win_q[rb][cr];
		end
	end

	for (genvar g = 0; g < CHANNEL_LANES; g++) begin : g_lane
		sem_pkg::nbhd_t nb;
		assign nb.tl = p_tl[g*PB +: PB];
		assign nb.tc = p_tc[g*PB +: PB];
		assign nb.tr = p_tr[g*PB +: PB];
		assign nb.ml = p_ml[g*PB +: PB];
		assign nb.mr = p_mr[g*PB +: PB];
		assign nb.bl = p_bl[g*PB +: PB];
		assign nb.bc = p_bc[g*PB +: PB];
		assign nb.br = p_br[g*PB +: PB];

		sem_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.nb     (nb),
			.done   (lane_done[g]),
			.mag    (lane_mag[g])
		);
	end

	sem_merge #(.LANES(CHANNEL_LANES)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (merge_start),
		.mag    (lane_mag),
		.nch    (eff_c),
		.done   (merge_done),
		.energy (merge_energy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.energy    <= merge_energy;
			out_q.frame_end <= fend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: sv/sem_chk.sv
// Port-level checker for the sobel energy map block, bound to the top level.
// Depends on sem_pkg and sobel_energy_map_unit_assert.svh.
`include "sobel_energy_map_unit_assert.svh"

module sem_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input sem_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input sem_pkg::out_t out_data
);

	// a stalled result beat holds
	`SEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// an accepted pixel beat always leaves the core busy, with in_ready low
	`SEM_ASSERT_NEXT(a_busy_after_pixel, in_valid && in_ready && !in_data.flush, !in_ready)

	// averaged magnitude never exceeds 1442, above 1140, the largest possible single-channel magnitude
	`SEM_ASSERT_NOW(a_energy_range, out_valid, out_data.energy <= 11'd1442)

endmodule

bind sobel_energy_map_unit sem_chk u_sem_chk (.*);
